// File: rtl/core/sat_pkg.sv
package sat_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = 5;

  localparam logic [ADDR_W-1:0] MAX_SEG_RESET = 32'd128;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_WRITE     = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MATCH,
    S_SEL,
    S_ADD
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic match_en;
    logic sel_en;
  } tbl_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
  } tbl_stat_t;

endpackage

// File: rtl/core/segment_address_translator_top.sv
// Channel   Direction  Handshake            Contents
// in_       request    in_valid/in_stall    op, logical address, slot write fields
// out_      result     out_valid/out_stall  translated address, split, length, hit
// cfg_      write      cfg_we               max segment size
//
// A translate request passes through 32 divider steps, a state that sees the divider finish,
// then the slot compare, the priority select and the add, which registers the result.
// The next request is accepted only once the translate has left its add step.
// A write request updates the table and gives its result on the next cycle, one per cycle unless stalled.
// Reset is synchronous and clears the slot valid bits and the control state.
// A stalled result holds in_stall high, and a finished translate waits in its add step.
module segment_address_translator_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sat_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [sat_pkg::ADDR_W-1:0] in_logical_address,
  input  logic [sat_pkg::SLOT_W-1:0] in_entry_slot,
  input  logic [sat_pkg::ADDR_W-1:0] in_entry_segment_id,
  input  logic [sat_pkg::ADDR_W-1:0] in_entry_base,
  input  logic [sat_pkg::ADDR_W-1:0] in_entry_length,
  input  logic                       in_entry_valid,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sat_pkg::ADDR_W-1:0] out_physical_address,
  output logic [sat_pkg::ADDR_W-1:0] out_segment_number,
  output logic [sat_pkg::ADDR_W-1:0] out_offset_in_segment,
  output logic [sat_pkg::ADDR_W-1:0] out_segment_length,
  output logic                       out_hit
);

  sat_pkg::state_t            state_r, state_nxt;
  logic [sat_pkg::ADDR_W-1:0] max_seg_r;
  logic                       in_accept;
  logic                       out_free;
  logic                       div_start;
  logic                       div_done;
  logic [sat_pkg::ADDR_W-1:0] quotient;
  logic [sat_pkg::ADDR_W-1:0] remainder;
  sat_pkg::tbl_ctrl_t         tbl_ctrl;
  sat_pkg::tbl_stat_t         tbl_stat;
  logic                       load_write;
  logic                       load_xlate;
  logic                       out_valid_r, out_valid_nxt;
  logic [sat_pkg::ADDR_W-1:0] phys_r;
  logic [sat_pkg::ADDR_W-1:0] seg_r;
  logic [sat_pkg::ADDR_W-1:0] off_r;
  logic [sat_pkg::ADDR_W-1:0] len_r;
  logic                       hit_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != sat_pkg::S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_seg_r <= sat_pkg::MAX_SEG_RESET;
    end else if (cfg_we) begin
      max_seg_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    div_start         = 1'b0;
    tbl_ctrl.wr_en    = 1'b0;
    tbl_ctrl.match_en = 1'b0;
    tbl_ctrl.sel_en   = 1'b0;
    load_write        = 1'b0;
    load_xlate        = 1'b0;
    unique case (state_r)
      sat_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_op == sat_pkg::OP_WRITE) begin
            tbl_ctrl.wr_en = 1'b1;
            load_write     = 1'b1;
          end else begin
            div_start = 1'b1;
            state_nxt = sat_pkg::S_DIV;
          end
        end
      end
      sat_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = sat_pkg::S_MATCH;
        end
      end
      sat_pkg::S_MATCH: begin
        tbl_ctrl.match_en = 1'b1;
        state_nxt         = sat_pkg::S_SEL;
      end
      sat_pkg::S_SEL: begin
        tbl_ctrl.sel_en = 1'b1;
        state_nxt       = sat_pkg::S_ADD;
      end
      sat_pkg::S_ADD: begin
        if (out_free) begin
          load_xlate = 1'b1;
          state_nxt  = sat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sat_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sat_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  sat_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_logical_address),
    .divisor   (max_seg_r),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  sat_tbl #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_tbl (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (tbl_ctrl),
    .wr_slot       (in_entry_slot),
    .wr_segment_id (in_entry_segment_id),
    .wr_base       (in_entry_base),
    .wr_length     (in_entry_length),
    .wr_valid      (in_entry_valid),
    .key           (quotient),
    .stat          (tbl_stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_write || load_xlate) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_write) begin
      phys_r <= '0;
      seg_r  <= '0;
      off_r  <= '0;
      len_r  <= '0;
      hit_r  <= 1'b0;
    end else if (load_xlate) begin
      phys_r <= tbl_stat.hit ? (tbl_stat.base + remainder) : '0;
      seg_r  <= quotient;
      off_r  <= remainder;
      len_r  <= tbl_stat.hit ? tbl_stat.length : '0;
      hit_r  <= tbl_stat.hit;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_physical_address  = phys_r;
  assign out_segment_number    = seg_r;
  assign out_offset_in_segment = off_r;
  assign out_segment_length    = len_r;
  assign out_hit               = hit_r;

endmodule

// File: rtl/core/sat_div.sv
module sat_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sat_pkg::ADDR_W-1:0] dividend,
  input  logic [sat_pkg::ADDR_W-1:0] divisor,
  output logic                       done,
  output logic [sat_pkg::ADDR_W-1:0] quotient,
  output logic [sat_pkg::ADDR_W-1:0] remainder
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [sat_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sat_pkg::ADDR_W-1:0] quo_r, quo_nxt;
  logic [sat_pkg::ADDR_W-1:0] rem_r, rem_nxt;
  logic [sat_pkg::ADDR_W-1:0] dvs_r, dvs_nxt;
  logic [sat_pkg::ADDR_W:0]   shifted;
  logic [sat_pkg::ADDR_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[sat_pkg::ADDR_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[sat_pkg::ADDR_W]) begin
        rem_nxt = diff[sat_pkg::ADDR_W-1:0];
        quo_nxt = {quo_r[sat_pkg::ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[sat_pkg::ADDR_W-1:0];
        quo_nxt = {quo_r[sat_pkg::ADDR_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sat_pkg::CNT_W'(sat_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/core/sat_tbl.sv
module sat_tbl #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sat_pkg::tbl_ctrl_t         ctrl,
  input  logic [sat_pkg::SLOT_W-1:0] wr_slot,
  input  logic [sat_pkg::ADDR_W-1:0] wr_segment_id,
  input  logic [sat_pkg::ADDR_W-1:0] wr_base,
  input  logic [sat_pkg::ADDR_W-1:0] wr_length,
  input  logic                       wr_valid,
  input  logic [sat_pkg::ADDR_W-1:0] key,
  output sat_pkg::tbl_stat_t         stat
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EXT_W = (IDX_W > sat_pkg::SLOT_W) ? IDX_W : sat_pkg::SLOT_W;

  logic [EXT_W-1:0]           slot_ext;
  logic [IDX_W-1:0]           wr_idx;
  logic                       wr_ok;
  logic [ENTRIES-1:0]         valid_r;
  logic [sat_pkg::ADDR_W-1:0] id_r [ENTRIES];
  logic [sat_pkg::ADDR_W-1:0] base_mem [ENTRIES];
  logic [sat_pkg::ADDR_W-1:0] len_mem [ENTRIES];
  logic [ENTRIES-1:0]         match_r;
  logic [IDX_W-1:0]           sel_idx;
  logic                       hit_r;
  logic [sat_pkg::ADDR_W-1:0] base_rd_r;
  logic [sat_pkg::ADDR_W-1:0] len_rd_r;

  assign slot_ext = EXT_W'(wr_slot);
  assign wr_idx   = slot_ext[IDX_W-1:0];
  assign wr_ok    = ctrl.wr_en && (32'(wr_slot) < ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      id_r[wr_idx]     <= wr_segment_id;
      base_mem[wr_idx] <= wr_base;
      len_mem[wr_idx]  <= wr_length;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.match_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_r[i] <= valid_r[i] && (id_r[i] == key);
      end
    end
  end

  // The lowest-numbered matching slot wins.
  always_comb begin
    sel_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sel_en) begin
      hit_r     <= |match_r;
      base_rd_r <= base_mem[sel_idx];
      len_rd_r  <= len_mem[sel_idx];
    end
  end

  assign stat.hit    = hit_r;
  assign stat.base   = base_rd_r;
  assign stat.length = len_rd_r;

endmodule

// File: test/tb_top.sv
module tb_top;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned LATENCY   = 40;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned RAND_REQS = 220;

  typedef struct packed {
    logic [sat_pkg::ADDR_W-1:0] phys;
    logic [sat_pkg::ADDR_W-1:0] seg;
    logic [sat_pkg::ADDR_W-1:0] off;
    logic [sat_pkg::ADDR_W-1:0] len;
    logic                       hit;
  } xlat_result_t;

  logic                       clk                 = 1'b0;
  logic                       rst_n               = 1'b0;
  logic                       cfg_we              = 1'b0;
  logic [sat_pkg::ADDR_W-1:0] cfg_wdata           = '0;
  logic                       in_valid            = 1'b0;
  logic                       in_op               = sat_pkg::OP_TRANSLATE;
  logic [sat_pkg::ADDR_W-1:0] in_logical_address  = '0;
  logic [sat_pkg::SLOT_W-1:0] in_entry_slot       = '0;
  logic [sat_pkg::ADDR_W-1:0] in_entry_segment_id = '0;
  logic [sat_pkg::ADDR_W-1:0] in_entry_base       = '0;
  logic [sat_pkg::ADDR_W-1:0] in_entry_length     = '0;
  logic                       in_entry_valid      = 1'b0;
  logic                       out_stall           = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [sat_pkg::ADDR_W-1:0] out_physical_address;
  logic [sat_pkg::ADDR_W-1:0] out_segment_number;
  logic [sat_pkg::ADDR_W-1:0] out_offset_in_segment;
  logic [sat_pkg::ADDR_W-1:0] out_segment_length;
  logic                       out_hit;

  logic [sat_pkg::ADDR_W-1:0] tbl_id    [SLOTS];
  logic [sat_pkg::ADDR_W-1:0] tbl_base  [SLOTS];
  logic [sat_pkg::ADDR_W-1:0] tbl_len   [SLOTS];
  logic                       tbl_valid [SLOTS];
  logic [sat_pkg::ADDR_W-1:0] seg_size;

  xlat_result_t pending_results[$];

  int errors       = 0;
  int n_checked    = 0;
  int n_translates = 0;
  int n_hits       = 0;
  int n_writes     = 0;
  int n_configs    = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;
  bit idle_on      = 1'b1;

  segment_address_translator_top #(
    .TABLE_ENTRIES(SLOTS)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_logical_address   (in_logical_address),
    .in_entry_slot        (in_entry_slot),
    .in_entry_segment_id  (in_entry_segment_id),
    .in_entry_base        (in_entry_base),
    .in_entry_length      (in_entry_length),
    .in_entry_valid       (in_entry_valid),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_physical_address (out_physical_address),
    .out_segment_number   (out_segment_number),
    .out_offset_in_segment(out_offset_in_segment),
    .out_segment_length   (out_segment_length),
    .out_hit              (out_hit)
  );

  always #2 clk = ~clk;

  task automatic compute_translation(input logic op,
                                     input logic [sat_pkg::ADDR_W-1:0] addr,
                                     input logic [sat_pkg::SLOT_W-1:0] slot,
                                     input logic [sat_pkg::ADDR_W-1:0] id,
                                     input logic [sat_pkg::ADDR_W-1:0] base,
                                     input logic [sat_pkg::ADDR_W-1:0] len,
                                     input logic v);
    xlat_result_t r;
    int i;
    r = '0;
    if (op == sat_pkg::OP_WRITE) begin
      tbl_id[slot]    = id;
      tbl_base[slot]  = base;
      tbl_len[slot]   = len;
      tbl_valid[slot] = v;
      n_writes++;
    end else begin
      if (seg_size == '0) begin
        r.seg = '1;
        r.off = addr;
      end else begin
        r.seg = addr / seg_size;
        r.off = addr % seg_size;
      end
      for (i = 0; i < SLOTS; i++) begin
        if (!r.hit && tbl_valid[i] && tbl_id[i] == r.seg) begin
          r.hit  = 1'b1;
          r.phys = tbl_base[i] + r.off;
          r.len  = tbl_len[i];
        end
      end
      n_translates++;
      if (r.hit) n_hits++;
    end
    pending_results.push_back(r);
  endtask

  task automatic send_request(input logic op,
                              input logic [sat_pkg::ADDR_W-1:0] addr,
                              input logic [sat_pkg::SLOT_W-1:0] slot,
                              input logic [sat_pkg::ADDR_W-1:0] id,
                              input logic [sat_pkg::ADDR_W-1:0] base,
                              input logic [sat_pkg::ADDR_W-1:0] len,
                              input logic v);
    while (idle_on && $urandom_range(99) < 21) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_op               <= op;
    in_logical_address  <= addr;
    in_entry_slot       <= slot;
    in_entry_segment_id <= id;
    in_entry_base       <= base;
    in_entry_length     <= len;
    in_entry_valid      <= v;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    compute_translation(op, addr, slot, id, base, len, v);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_seg_size(input logic [sat_pkg::ADDR_W-1:0] value);
    drain;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    seg_size  = value;
    n_configs++;
  endtask

  function automatic logic [sat_pkg::ADDR_W-1:0] pick_segment_id();
    logic [63:0] limit;
    if ($urandom_range(99) < 10) return $urandom;
    if (seg_size == '0) return ($urandom_range(1) != 0) ? '1 : $urandom;
    limit = 64'(32'hFFFF_FFFF / seg_size);
    if (limit > 64) limit = ($urandom_range(1) != 0) ? 64'd64 : limit;
    return sat_pkg::ADDR_W'(64'($urandom) % (limit + 64'd1));
  endfunction

  task automatic send_random;
    int s;
    logic [63:0] a;
    s = $urandom_range(SLOTS - 1);
    if ($urandom_range(99) < 30) begin
      send_request(sat_pkg::OP_WRITE, $urandom, sat_pkg::SLOT_W'(s), pick_segment_id(),
                   $urandom, $urandom, $urandom_range(99) < 85);
    end else begin
      a = 64'($urandom);
      if (seg_size != '0 && tbl_valid[s] && $urandom_range(99) < 75) begin
        a = 64'(tbl_id[s]) * 64'(seg_size) + 64'($urandom % seg_size);
        if (a > 64'hFFFF_FFFF) a = 64'($urandom);
      end
      send_request(sat_pkg::OP_TRANSLATE, a[sat_pkg::ADDR_W-1:0], sat_pkg::SLOT_W'($urandom),
                   $urandom, $urandom, $urandom, $urandom_range(1) != 0);
    end
  endtask

  function automatic void check_field(input string name,
                                      input logic [sat_pkg::ADDR_W-1:0] exp,
                                      input logic [sat_pkg::ADDR_W-1:0] act);
    if (exp !== act) begin
      if (errors < 10) $display("mismatch on %s: expected %h, got %h", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    xlat_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (errors < 10) $display("result with no request waiting for it");
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("physical_address", e.phys, out_physical_address);
        check_field("segment_number", e.seg, out_segment_number);
        check_field("offset_in_segment", e.off, out_offset_in_segment);
        check_field("segment_length", e.len, out_segment_length);
        check_field("hit", sat_pkg::ADDR_W'(e.hit), sat_pkg::ADDR_W'(out_hit));
        n_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 21);
    end
  end

  task automatic test_table_basics;
    send_request(sat_pkg::OP_TRANSLATE, 32'h0000_0000, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, '1, '1, '1, '1, 1'b1);
    send_request(sat_pkg::OP_WRITE, '0, 4'd0, 32'd5, 32'h0000_1000, 32'h80, 1'b1);
    send_request(sat_pkg::OP_TRANSLATE, 32'd643, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_WRITE, '0, 4'd3, 32'd5, 32'h0000_2000, 32'h40, 1'b1);
    send_request(sat_pkg::OP_TRANSLATE, 32'd643, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_WRITE, '1, 4'd0, 32'd5, '1, '1, 1'b0);
    send_request(sat_pkg::OP_TRANSLATE, 32'd643, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_WRITE, '0, 4'd15, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);
    send_request(sat_pkg::OP_TRANSLATE, 32'h0000_007F, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_WRITE, '0, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_request(sat_pkg::OP_WRITE, '1, 4'd8, '1, '1, '1, 1'b0);
  endtask

  task automatic test_divisor_extremes;
    set_seg_size(32'h0000_0000);
    send_request(sat_pkg::OP_TRANSLATE, 32'h1234_5678, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_TRANSLATE, 32'h0000_0000, '0, '0, '0, '0, 1'b0);
    set_seg_size(32'h0000_0001);
    send_request(sat_pkg::OP_TRANSLATE, 32'd5, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_TRANSLATE, 32'd0, '0, '0, '0, '0, 1'b0);
    set_seg_size(32'hFFFF_FFFF);
    send_request(sat_pkg::OP_TRANSLATE, 32'hFFFF_FFFE, '0, '0, '0, '0, 1'b0);
    send_request(sat_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic test_random_sizes;
    logic [sat_pkg::ADDR_W-1:0] sizes [8];
    int k;
    sizes = '{32'd128, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd16, 32'd100,
              sat_pkg::ADDR_W'($urandom_range(1 << 20, 2)), $urandom};
    for (k = 0; k < 8; k++) begin
      set_seg_size(sizes[k]);
      repeat (RAND_REQS) send_random;
    end
  endtask

  task automatic test_output_hold_off;
    set_seg_size(32'd64);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random;
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back;
    idle_on = 1'b0;
    repeat (200) send_random;
    idle_on = 1'b1;
  endtask

  initial begin
    int k;
    seg_size = sat_pkg::MAX_SEG_RESET;
    for (k = 0; k < SLOTS; k++) tbl_valid[k] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_table_basics;
    test_divisor_extremes;
    test_random_sizes;
    test_output_hold_off;
    test_back_to_back;

    @(negedge clk);
    in_valid <= 1'b0;
    for (k = 0; k < 20000 && pending_results.size() != 0; k++) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    $display("Checked %0d results: %0d translations (%0d hits), %0d table writes.",
             n_checked, n_translates, n_hits, n_writes);
    $display("The segment size was set %0d times, including zero, one and all ones.",
             n_configs);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
